[rtl/core/sitda_pkg.sv]
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared widths, constants and types for the signed integer to decimal text
// converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int MAG_WIDTH   = VALUE_WIDTH;

	// Decimal digits of the largest magnitude, 2^(VALUE_WIDTH-1).
	localparam int NUM_DIGITS  = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
	localparam int DIGIT_IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam int BIT_CNT_W   = $clog2(MAG_WIDTH);

	localparam int CHAR_W = 8;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;
	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = 1;
	localparam int QUEUE_CNT_W = 2;

	typedef struct packed {
		logic                 neg;
		logic [MAG_WIDTH-1:0] mag;
	} conv_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

[rtl/core/signed_int_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Turns each signed integer into its decimal text, one ASCII character per
// output transaction, most significant first, with last on the final one.
// ----------------------------------------------------------------------------
// A value is first taken up from the queue, then converted one magnitude bit
// at a time by the shift-and-add-three converter; next the leading digit is
// found, and the characters go out one at a time, each held back while the
// output is stalled. The converter and the character output are one
// sequential unit, so a new value is taken up from the queue only once the
// last character of the previous one is in the output register. The input
// side keeps accepting while the converter is busy, until its register and
// the two-entry queue are full.
module signed_int_to_decimal_ascii (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic signed [sitda_pkg::VALUE_WIDTH-1:0] value,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic [sitda_pkg::CHAR_W-1:0]             character,
	output logic                                     last
);

	sitda_pkg::queue_status_t q_status;
	sitda_pkg::conv_item_t    push_item;
	sitda_pkg::conv_item_t    pop_item;
	logic                     push;
	logic                     pop;

	sitda_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.q_status  (q_status),
		.push      (push),
		.push_item (push_item)
	);

	sitda_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.q_status  (q_status)
	);

	sitda_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.pop_item  (pop_item),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.character (character),
		.last      (last)
	);

endmodule

[rtl/core/sitda_front.sv]
// ----------------------------------------------------------------------------
// sitda_front
// Accepts input transactions, splits each value into sign and unsigned
// magnitude and hands the result to the queue.
// ----------------------------------------------------------------------------
module sitda_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [sitda_pkg::VALUE_WIDTH-1:0] value,
	input  sitda_pkg::queue_status_t               q_status,
	output logic                                   push,
	output sitda_pkg::conv_item_t                  push_item
);

	logic                  valid_s1;
	sitda_pkg::conv_item_t item_s1;
	logic [sitda_pkg::MAG_WIDTH-1:0] neg_mag;

	assign neg_mag   = sitda_pkg::MAG_WIDTH'(-value);
	assign in_stall  = valid_s1 && q_status.full;
	assign push      = valid_s1 && !q_status.full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1.neg <= value[sitda_pkg::VALUE_WIDTH-1];
			item_s1.mag <= value[sitda_pkg::VALUE_WIDTH-1] ? neg_mag
				: sitda_pkg::MAG_WIDTH'(value);
		end
	end

endmodule

[rtl/core/sitda_queue.sv]
// ----------------------------------------------------------------------------
// sitda_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module sitda_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  sitda_pkg::conv_item_t     push_item,
	input  logic                      pop,
	output sitda_pkg::conv_item_t     pop_item,
	output sitda_pkg::queue_status_t  q_status
);

	sitda_pkg::conv_item_t                entry_q [sitda_pkg::QUEUE_DEPTH];
	logic [sitda_pkg::QUEUE_PTR_W-1:0]    wr_ptr_q;
	logic [sitda_pkg::QUEUE_PTR_W-1:0]    rd_ptr_q;
	logic [sitda_pkg::QUEUE_CNT_W-1:0]    count_q;
	logic                                 do_push;
	logic                                 do_pop;

	assign q_status.full  = (count_q == sitda_pkg::QUEUE_CNT_W'(sitda_pkg::QUEUE_DEPTH));
	assign q_status.empty = (count_q == '0);
	assign do_push        = push && !q_status.full;
	assign do_pop         = pop && !q_status.empty;
	assign pop_item       = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

[rtl/core/sitda_back.sv]
// ----------------------------------------------------------------------------
// sitda_back
// Converts a magnitude to decimal digits by shift-and-add-three, one bit a
// cycle, then sends the sign and the digits out one character a transaction.
// ----------------------------------------------------------------------------
module sitda_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sitda_pkg::queue_status_t         q_status,
	input  sitda_pkg::conv_item_t            pop_item,
	output logic                             pop,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [sitda_pkg::CHAR_W-1:0]     character,
	output logic                             last
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CONV  = 3'd1;
	localparam logic [2:0] ST_LEAD  = 3'd2;
	localparam logic [2:0] ST_SIGN  = 3'd3;
	localparam logic [2:0] ST_DIGIT = 3'd4;

	logic [2:0]                          state_q;
	logic [sitda_pkg::BIT_CNT_W-1:0]     bit_cnt_q;
	logic [sitda_pkg::DIGIT_IDX_W-1:0]   idx_q;
	logic                                neg_q;
	logic [sitda_pkg::MAG_WIDTH-1:0]     mag_q;
	logic [3:0]                          bcd_q   [sitda_pkg::NUM_DIGITS];
	logic [3:0]                          bcd_adj [sitda_pkg::NUM_DIGITS];
	logic [3:0]                          bcd_nxt [sitda_pkg::NUM_DIGITS];
	logic [sitda_pkg::DIGIT_IDX_W-1:0]   top_idx;
	logic                                out_valid_q;
	logic [sitda_pkg::CHAR_W-1:0]        character_q;
	logic                                last_q;
	logic                                out_free;
	logic                                emit;

	assign out_valid = out_valid_q;
	assign character = character_q;
	assign last      = last_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign emit      = ((state_q == ST_SIGN) || (state_q == ST_DIGIT)) && out_free;
	assign pop       = (state_q == ST_IDLE) && !q_status.empty;

	always_comb begin
		for (int i = 0; i < sitda_pkg::NUM_DIGITS; i++) begin
			bcd_adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
		bcd_nxt[0] = {bcd_adj[0][2:0], mag_q[sitda_pkg::MAG_WIDTH-1]};
		for (int i = 1; i < sitda_pkg::NUM_DIGITS; i++) begin
			bcd_nxt[i] = {bcd_adj[i][2:0], bcd_adj[i-1][3]};
		end
	end

	always_comb begin
		top_idx = '0;
		for (int i = 0; i < sitda_pkg::NUM_DIGITS; i++) begin
			if (bcd_q[i] != 4'd0) begin
				top_idx = sitda_pkg::DIGIT_IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bit_cnt_q   <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= emit || (out_valid_q && out_stall);
			unique case (state_q)
				ST_IDLE: begin
					if (!q_status.empty) begin
						bit_cnt_q <= '0;
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q + 1'b1;
					if (bit_cnt_q == sitda_pkg::BIT_CNT_W'(sitda_pkg::MAG_WIDTH - 1)) begin
						state_q <= ST_LEAD;
					end
				end
				ST_LEAD: begin
					idx_q   <= top_idx;
					state_q <= neg_q ? ST_SIGN : ST_DIGIT;
				end
				ST_SIGN: begin
					if (out_free) begin
						state_q <= ST_DIGIT;
					end
				end
				ST_DIGIT: begin
					if (out_free) begin
						if (idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && !q_status.empty) begin
			neg_q <= pop_item.neg;
			mag_q <= pop_item.mag;
			for (int i = 0; i < sitda_pkg::NUM_DIGITS; i++) begin
				bcd_q[i] <= 4'd0;
			end
		end else if (state_q == ST_CONV) begin
			mag_q <= {mag_q[sitda_pkg::MAG_WIDTH-2:0], 1'b0};
			for (int i = 0; i < sitda_pkg::NUM_DIGITS; i++) begin
				bcd_q[i] <= bcd_nxt[i];
			end
		end
		if (state_q == ST_SIGN && out_free) begin
			character_q <= sitda_pkg::ASCII_MINUS;
			last_q      <= 1'b0;
		end else if (state_q == ST_DIGIT && out_free) begin
			character_q <= sitda_pkg::ASCII_ZERO + {4'd0, bcd_q[idx_q]};
			last_q      <= (idx_q == '0);
		end
	end

endmodule

[rtl/core/sitda_checker.sv]
// ----------------------------------------------------------------------------
// sitda_checker
// Port-level checks on the converter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module sitda_checker (
	input logic                                     clk,
	input logic                                     arst_n,
	input logic                                     in_valid,
	input logic                                     in_stall,
	input logic signed [sitda_pkg::VALUE_WIDTH-1:0] value,
	input logic                                     out_valid,
	input logic                                     out_stall,
	input logic [sitda_pkg::CHAR_W-1:0]             character,
	input logic                                     last
);

	// A stalled input transaction holds until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(value))
		else $error("input changed while stalled");

	// A stalled result holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(character) && $stable(last))
		else $error("result changed while stalled");

	// Every character is a minus sign or a decimal digit.
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (character == sitda_pkg::ASCII_MINUS) ||
			((character >= sitda_pkg::ASCII_ZERO) && (character <= 8'd57)))
		else $error("character outside the decimal set");

	// The minus sign never ends a number.
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (character == sitda_pkg::ASCII_MINUS) |-> !last)
		else $error("minus sign flagged as last");

	// A minus sign taken is followed by a non-zero leading digit.
	a_no_minus_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && (character == sitda_pkg::ASCII_MINUS) ##1
			out_valid |-> (character != sitda_pkg::ASCII_ZERO))
		else $error("zero follows a minus sign");

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.value     (value),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.character (character),
	.last      (last)
);

[tb/signed_int_to_decimal_ascii_tb.sv]
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_tb
// Drives signed integers into the decimal text converter and checks every
// output character and its last flag against a predicted text. The predicted
// text is formed when each value is accepted. Both sides idle at random, and
// one long output hold-off fills the converter until it stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_tb;

	localparam int DIGIT_BUF      = 24;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_OFF_LEN   = 600;
	localparam int TAIL_CYCLES    = 100;
	localparam int REPORT_LIMIT   = 10;

	typedef struct {
		logic [sitda_pkg::CHAR_W-1:0] code;
		logic                         last;
	} text_char_t;

	logic                                     clk       = 1'b0;
	logic                                     arst_n    = 1'b0;
	logic                                     in_valid  = 1'b0;
	logic                                     in_stall;
	logic signed [sitda_pkg::VALUE_WIDTH-1:0] value     = '0;
	logic                                     out_valid;
	logic                                     out_stall = 1'b0;
	logic [sitda_pkg::CHAR_W-1:0]             character;
	logic                                     last;

	logic signed [sitda_pkg::VALUE_WIDTH-1:0] values_to_send[$];
	text_char_t                               expected_text[$];

	bit tx_idle_en = 1'b0;
	bit rx_idle_en = 1'b0;
	bit rx_hold    = 1'b0;

	int tx_gap        = 0;
	int rx_gap        = 0;
	int values_queued = 0;
	int values_taken  = 0;
	int chars_checked = 0;
	int negatives     = 0;
	int mismatches    = 0;
	int input_stalls  = 0;
	int quiet_cycles  = 0;

	signed_int_to_decimal_ascii dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.character (character),
		.last      (last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Mostly short gaps, with the occasional long one.
	function automatic int pick_gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			return $urandom_range(1, 3);
		end else if (r < 96) begin
			return $urandom_range(4, 12);
		end else begin
			return $urandom_range(20, 60);
		end
	endfunction

	function automatic void predict_text(logic signed [sitda_pkg::VALUE_WIDTH-1:0] v);
		logic [sitda_pkg::VALUE_WIDTH-1:0] mag;
		logic [sitda_pkg::CHAR_W-1:0]      digits[DIGIT_BUF];
		logic                              neg;
		text_char_t                        ch;
		int                                n;
		neg = v[sitda_pkg::VALUE_WIDTH-1];
		mag = neg ? -v : v;
		n = 0;
		do begin
			digits[n] = sitda_pkg::ASCII_ZERO + sitda_pkg::CHAR_W'(mag % 10);
			mag = mag / 10;
			n++;
		end while (mag != 0 && n < DIGIT_BUF);
		if (neg) begin
			ch.code = sitda_pkg::ASCII_MINUS;
			ch.last = 1'b0;
			expected_text.push_back(ch);
			negatives++;
		end
		for (int k = n - 1; k >= 0; k--) begin
			ch.code = digits[k];
			ch.last = (k == 0);
			expected_text.push_back(ch);
		end
	endfunction

	function automatic void report_mismatch(string what);
		mismatches++;
		if (mismatches <= REPORT_LIMIT) begin
			$display("%0t: %s", $realtime, what);
		end
	endfunction

	function automatic void queue_value(logic signed [sitda_pkg::VALUE_WIDTH-1:0] v);
		values_to_send.push_back(v);
		values_queued++;
	endfunction

	// Values of a random digit count and sign, with some fully random words.
	function automatic logic signed [sitda_pkg::VALUE_WIDTH-1:0] random_value();
		longint mag;
		longint lim;
		longint bound;
		bit     neg;
		int     ndig;
		if ($urandom_range(0, 3) == 0) begin
			return $urandom();
		end
		neg = $urandom_range(0, 1);
		ndig = $urandom_range(1, 10);
		bound = 1;
		repeat (ndig) bound = bound * 10;
		mag = {$urandom(), $urandom()} & 64'h7fff_ffff_ffff_ffff;
		mag = mag % bound;
		lim = neg ? 64'd2147483649 : 64'd2147483648;
		if (mag >= lim) begin
			mag = mag % lim;
		end
		return neg ? sitda_pkg::VALUE_WIDTH'(-mag) : sitda_pkg::VALUE_WIDTH'(mag);
	endfunction

	// Sender: valid is held with a stable payload until the transaction is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			value <= '0;
		end else begin
			if (in_valid && in_stall) begin
				input_stalls++;
			end
			if (in_valid && !in_stall) begin
				predict_text(value);
				values_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (values_to_send.size() > 0) begin
					in_valid <= 1'b1;
					value <= values_to_send.pop_front();
					if (tx_idle_en && $urandom_range(0, 2) == 0) begin
						tx_gap = pick_gap_len();
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each character transaction, then chooses its stall.
	always @(posedge clk or negedge arst_n) begin
		text_char_t ch;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				chars_checked++;
				if (expected_text.size() == 0) begin
					report_mismatch($sformatf("unexpected character %0d last %0b",
						character, last));
				end else begin
					ch = expected_text.pop_front();
					if (character !== ch.code || last !== ch.last) begin
						report_mismatch($sformatf(
							"character expected %0d last %0b, got %0d last %0b",
							ch.code, ch.last, character, last));
					end
				end
			end
			if (rx_gap > 0) begin
				rx_gap--;
			end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
				rx_gap = pick_gap_len();
			end
			out_stall <= rx_hold || (rx_gap > 0);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired with %0d characters outstanding.",
				expected_text.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic drain();
		while (values_taken != values_queued || expected_text.size() != 0) begin
			@(negedge clk);
		end
	endtask

	initial begin
		logic signed [sitda_pkg::VALUE_WIDTH-1:0] directed[$];
		directed = '{0, 1, -1, 7, -7, 9, 10, -10, 99, 100, -100, 1000000,
			999999999, -999999999, 1000000000, 1234567890, -1234567890,
			2147483647, -2147483647, 32'sh8000_0000, 32'sh5555_5555,
			32'shAAAA_AAAA};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		foreach (directed[i]) queue_value(directed[i]);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			tx_idle_en = phase[0];
			rx_idle_en = phase[1];
			repeat (95) queue_value(random_value());
			drain();
		end

		// Output held off while the sender keeps offering values.
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		rx_hold = 1'b1;
		repeat (30) queue_value(random_value());
		repeat (HOLD_OFF_LEN) @(negedge clk);
		rx_hold = 1'b0;
		drain();

		repeat (TAIL_CYCLES) @(negedge clk);
		while (expected_text.size() > 0) begin
			void'(expected_text.pop_front());
			report_mismatch("expected character never arrived");
		end

		$display("Converted %0d values (%0d negative) into %0d characters.",
			values_taken, negatives, chars_checked);
		$display("Input was stalled in %0d cycles; %0d mismatches seen.",
			input_stalls, mismatches);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/core/sitda_pkg.sv
rtl/core/sitda_front.sv
rtl/core/sitda_queue.sv
rtl/core/sitda_back.sv
rtl/core/signed_int_to_decimal_ascii.sv
rtl/core/sitda_checker.sv
tb/signed_int_to_decimal_ascii_tb.sv
